/* hdl/assert_macros.svh */
// Assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define AT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// Next-cycle implication, checked outside reset.
`define AT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define AT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define AT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/atcp_pkg.sv */
// Shared constants, types and character helpers of the AT command parser.
`default_nettype none
package atcp_pkg;

   localparam int BUFFER_BYTES_DEF = 64;
   localparam int TABLE_ENTRIES    = 3;
   localparam int NAME_SLOTS       = 3;
   localparam int ENTRY_COUNT      = (TABLE_ENTRIES < NAME_SLOTS) ? TABLE_ENTRIES : NAME_SLOTS;
   localparam logic [NAME_SLOTS-1:0] ENTRY_MASK = NAME_SLOTS'((1 << ENTRY_COUNT) - 1);

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_A   = 8'h41;
   localparam logic [7:0] CHAR_T   = 8'h54;
   localparam logic [7:0] CHAR_EQ  = 8'h3D;
   localparam logic [7:0] CHAR_QM  = 8'h3F;
   localparam logic [7:0] CHAR_0   = 8'h30;
   localparam logic [7:0] CHAR_9   = 8'h39;

   localparam logic [39:0] NAME_QUIT = "+QUIT";
   localparam logic [31:0] NAME_INF  = "+INF";

   localparam logic [1:0] IDX_EMPTY = 2'd0;
   localparam logic [1:0] IDX_QUIT  = 2'd1;
   localparam logic [1:0] IDX_INF   = 2'd2;
   localparam logic [1:0] NO_MATCH  = 2'd3;

   localparam logic [2:0] KIND_EXECUTE   = 3'd0;
   localparam logic [2:0] KIND_QUERY     = 3'd1;
   localparam logic [2:0] KIND_TEST      = 3'd2;
   localparam logic [2:0] KIND_SETUP     = 3'd3;
   localparam logic [2:0] KIND_MALFORMED = 3'd4;

   typedef struct packed {
      logic                  is_zero;
      logic                  is_term;
      logic [NAME_SLOTS-1:0] name_hit;
      logic [NAME_SLOTS-1:0] len_hit;
   } byte_class_type;

   typedef struct packed {
      logic [1:0] command_index;
      logic [2:0] request_kind;
      logic       error;
      logic       production_mode;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_0) && (c <= CHAR_9);
   endfunction

   function automatic logic [2:0] name_len(input logic [1:0] entry);
      logic [2:0] len;
      case (entry)
         IDX_QUIT: len = 3'd5;
         IDX_INF:  len = 3'd4;
         default:  len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] name_char(input logic [1:0] entry, input logic [2:0] pos);
      logic [7:0] c;
      c = CHAR_NUL;
      case (entry)
         IDX_QUIT: if (pos < 3'd5) c = NAME_QUIT[39 - 8 * pos -: 8];
         IDX_INF:  if (pos < 3'd4) c = NAME_INF[31 - 8 * pos -: 8];
         default:  c = CHAR_NUL;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

/* hdl/at_command_parser_unit.sv */
// AT command parser top level: byte capture, parse sequencer and result register.
//
//  channel  | direction | ports                                   | accepted when
//  req      | in        | req_valid, req_stall, req_rx_byte       | req_valid && !req_stall
//  rsp      | out       | rsp_valid, rsp_stall, rsp_<result>      | rsp_valid && !rsp_stall
//
// A byte that is not the closing carriage return does not raise req_stall.
// After a carriage return the parser walks the capture one byte a cycle through
// the shared compare unit: req_stall is high while the start pulse is out and while
// the parser is busy in its name, suffix and done states, so also while the result
// waits on a stalled output register. Reset clears head hunt, capture and production
// mode; the byte buffer holds no reset value.
`default_nettype none
`include "assert_macros.svh"
module at_command_parser_unit #(
   parameter int BUFFER_BYTES = atcp_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_command_index,
   output logic [2:0]      rsp_request_kind,
   output logic            rsp_error,
   output logic            rsp_production_mode
);
   import atcp_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_BYTES);
   localparam int CNT_W = $clog2(BUFFER_BYTES + 2);

   logic             req_accept;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic [CNT_W-1:0] fill;
   logic             start;
   logic             par_busy;
   logic             par_valid;
   logic             take;
   result_type       par_result;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;
   logic             rsp_ok_beat;
   logic             rsp_known_ok;

   assign req_stall  = start | par_busy;
   assign req_accept = req_valid && !req_stall;
   assign take       = !rsp_valid_ff || !rsp_stall;

   atcp_rx #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_rx (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .rx_byte(req_rx_byte),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .fill   (fill),
      .start  (start)
   );

   atcp_parse #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .fill     (fill),
      .rd_data  (rd_data),
      .rd_addr  (rd_addr),
      .take     (take),
      .busy     (par_busy),
      .res_valid(par_valid),
      .result   (par_result)
   );

   always_comb begin
      if (par_valid && take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (par_valid && take) begin
         rsp_data_ff <= par_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_command_index   = rsp_data_ff.command_index;
   assign rsp_request_kind    = rsp_data_ff.request_kind;
   assign rsp_error           = rsp_data_ff.error;
   assign rsp_production_mode = rsp_data_ff.production_mode;

   assign rsp_ok_beat  = rsp_valid_ff && !rsp_data_ff.error;
   assign rsp_known_ok = (rsp_data_ff.command_index != NO_MATCH) &&
                         (rsp_data_ff.request_kind == KIND_EXECUTE ||
                          rsp_data_ff.request_kind == KIND_QUERY);

   `AT_ASSERT_IMPLY(a_start_follows_beat, clock, reset, start, $past(req_accept))
   `AT_ASSERT_IMPLY(a_ok_only_known_cmd, clock, reset, rsp_ok_beat, rsp_known_ok)
   `AT_ASSERT_NEXT(a_result_held, clock, reset, par_valid && !take, par_valid)

endmodule
`default_nettype wire

/* hdl/atcp_rx.sv */
// Head hunter, capture counter and command byte buffer.
`default_nettype none
module atcp_rx #(
   parameter int BUFFER_BYTES = atcp_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  accept,
   input  wire logic [7:0]                            rx_byte,
   input  wire logic [$clog2(BUFFER_BYTES)-1:0]       rd_addr,
   output logic [7:0]                                 rd_data,
   output logic [$clog2(BUFFER_BYTES+2)-1:0]          fill,
   output logic                                       start
);
   import atcp_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_BYTES);
   localparam int CNT_W = $clog2(BUFFER_BYTES + 2);

   logic [7:0]       mem [BUFFER_BYTES];
   logic [7:0]       rd_data_ff;
   logic             head_pos_ff, head_pos_in;
   logic             capturing_ff, capturing_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             start_ff, start_in;
   logic [7:0]       want;

   always_comb begin
      head_pos_in  = head_pos_ff;
      capturing_in = capturing_ff;
      fill_in      = fill_ff;
      start_in     = 1'b0;
      want         = head_pos_ff ? CHAR_T : CHAR_A;
      if (accept) begin
         if (!capturing_ff) begin
            if (rx_byte == want) begin
               if (head_pos_ff) begin
                  head_pos_in  = 1'b0;
                  capturing_in = 1'b1;
                  fill_in      = '0;
               end else begin
                  head_pos_in = 1'b1;
               end
            end else begin
               // restart; an 'A' counts as the first head character
               head_pos_in = (rx_byte == CHAR_A);
            end
         end else begin
            fill_in = fill_ff + CNT_W'(1);
            if (rx_byte == CHAR_CR) begin
               capturing_in = 1'b0;
               start_in     = 1'b1;
            end else if (fill_in >= CNT_W'(BUFFER_BYTES)) begin
               // buffer full without CR: drop the capture
               capturing_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_pos_ff  <= 1'b0;
         capturing_ff <= 1'b0;
         fill_ff      <= '0;
         start_ff     <= 1'b0;
      end else begin
         head_pos_ff  <= head_pos_in;
         capturing_ff <= capturing_in;
         fill_ff      <= fill_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && capturing_ff) begin
         mem[fill_ff[IDX_W-1:0]] <= rx_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;
   assign start   = start_ff;

endmodule
`default_nettype wire

/* hdl/atcp_byte_unit.sv */
// Shared byte compare unit: zero and terminator check, name character and length match.
`default_nettype none
module atcp_byte_unit #(
   parameter int BUFFER_BYTES = atcp_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic [7:0]                          cur_byte,
   input  wire logic [$clog2(BUFFER_BYTES+2)-1:0]   pos,
   output atcp_pkg::byte_class_type                 cls
);
   import atcp_pkg::*;

   localparam int CNT_W = $clog2(BUFFER_BYTES + 2);

   always_comb begin
      cls.is_zero = (cur_byte == CHAR_NUL);
      cls.is_term = (cur_byte == CHAR_CR) || (cur_byte == CHAR_EQ) ||
                    (cur_byte == CHAR_QM) || is_digit(cur_byte);
      for (int i = 0; i < NAME_SLOTS; i++) begin
         cls.name_hit[i] = (pos < CNT_W'(name_len(2'(i)))) &&
                           (cur_byte == name_char(2'(i), pos[2:0]));
         cls.len_hit[i]  = (pos == CNT_W'(name_len(2'(i))));
      end
   end

endmodule
`default_nettype wire

/* hdl/atcp_parse.sv */
// Parse sequencer: walks the captured bytes once through the shared byte unit.
`default_nettype none
module atcp_parse #(
   parameter int BUFFER_BYTES = atcp_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [$clog2(BUFFER_BYTES+2)-1:0]   fill,
   input  wire logic [7:0]                          rd_data,
   output logic [$clog2(BUFFER_BYTES)-1:0]          rd_addr,
   input  wire logic                                take,
   output logic                                     busy,
   output logic                                     res_valid,
   output atcp_pkg::result_type                     result
);
   import atcp_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_BYTES);
   localparam int CNT_W = $clog2(BUFFER_BYTES + 2);

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_NAME = 3'd1;
   localparam logic [2:0] P_SUF1 = 3'd2;
   localparam logic [2:0] P_SUF2 = 3'd3;
   localparam logic [2:0] P_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [NAME_SLOTS-1:0] match_ff, match_in;
   logic [NAME_SLOTS-1:0] hit;
   logic [1:0]            idx_ff, idx_in;
   logic [2:0]            kind_ff, kind_in;
   logic                  err_ff, err_in;
   logic                  prod_ff, prod_in;
   logic [7:0]            s0_ff, s0_in;
   logic [7:0]            s1_ff, s1_in;
   logic [7:0]            cur_byte;
   byte_class_type        cls;

   // bytes past the stored capture read as zero
   assign cur_byte = (pos_ff < fill) ? rd_data : CHAR_NUL;

   atcp_byte_unit #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_byte_unit (
      .cur_byte(cur_byte),
      .pos     (pos_ff),
      .cls     (cls)
   );

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      match_in = match_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      err_in   = err_ff;
      prod_in  = prod_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      hit      = match_ff & cls.len_hit;
      case (state_ff)
         P_IDLE: begin
            pos_in = '0;
            if (start) begin
               state_in = P_NAME;
               match_in = ENTRY_MASK;
            end
         end
         P_NAME: begin
            pos_in = pos_ff + CNT_W'(1);
            if (cls.is_zero) begin
               idx_in   = NO_MATCH;
               kind_in  = KIND_EXECUTE;
               err_in   = 1'b1;
               state_in = P_DONE;
            end else if (cls.is_term) begin
               s0_in = cur_byte;
               if (hit[0]) begin
                  idx_in = IDX_EMPTY;
               end else if (hit[1]) begin
                  idx_in = IDX_QUIT;
               end else if (hit[2]) begin
                  idx_in = IDX_INF;
               end else begin
                  idx_in = NO_MATCH;
               end
               if (hit == '0) begin
                  kind_in  = KIND_EXECUTE;
                  err_in   = 1'b1;
                  state_in = P_DONE;
               end else begin
                  state_in = P_SUF1;
               end
            end else begin
               match_in = match_ff & cls.name_hit;
            end
         end
         P_SUF1: begin
            pos_in   = pos_ff + CNT_W'(1);
            s1_in    = cur_byte;
            state_in = P_SUF2;
         end
         P_SUF2: begin
            if (s0_ff == CHAR_CR) begin
               kind_in = KIND_EXECUTE;
            end else if (s0_ff == CHAR_QM && s1_ff == CHAR_CR) begin
               kind_in = KIND_QUERY;
            end else if (s0_ff == CHAR_EQ && s1_ff == CHAR_QM && cur_byte == CHAR_CR) begin
               kind_in = KIND_TEST;
            end else if (is_digit(s0_ff) || s0_ff == CHAR_EQ) begin
               kind_in = KIND_SETUP;
            end else begin
               kind_in = KIND_MALFORMED;
            end
            err_in = 1'b1;
            if (kind_in == KIND_EXECUTE && idx_ff == IDX_EMPTY) begin
               prod_in = 1'b1;
               err_in  = 1'b0;
            end else if (kind_in == KIND_EXECUTE && idx_ff == IDX_QUIT) begin
               prod_in = 1'b0;
               err_in  = 1'b0;
            end else if (kind_in == KIND_QUERY && idx_ff == IDX_INF) begin
               err_in = 1'b0;
            end
            state_in = P_DONE;
         end
         P_DONE: begin
            // hold the result until the output register takes it
            if (take) begin
               state_in = P_IDLE;
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         prod_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         prod_ff  <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      match_ff <= match_in;
      idx_ff   <= idx_in;
      kind_ff  <= kind_in;
      err_ff   <= err_in;
      s0_ff    <= s0_in;
      s1_ff    <= s1_in;
   end

   assign rd_addr                = pos_in[IDX_W-1:0];
   assign busy                   = (state_ff != P_IDLE);
   assign res_valid              = (state_ff == P_DONE);
   assign result.command_index   = idx_ff;
   assign result.request_kind    = kind_ff;
   assign result.error           = err_ff;
   assign result.production_mode = prod_ff;

endmodule
`default_nettype wire

/* test/at_command_parser_unit_tb.sv */
// Self-checking testbench for the AT command parser: byte stimulus, result predictor, checks.
`timescale 1ns / 1ps

import atcp_pkg::*;

class command_result_board;
   localparam int CAPTURE_BYTES = BUFFER_BYTES_DEF;

   bit          head_half;
   bit          in_capture;
   int unsigned fill;
   logic [7:0]  capture_mem[CAPTURE_BYTES];
   bit          prod_mode;
   string       entry_name[NAME_SLOTS] = '{"", "+QUIT", "+INF"};
   result_type  pending_results[$];
   int          mismatch_count;

   function automatic bit is_num_char(logic [7:0] c);
      return c >= CHAR_0 && c <= CHAR_9;
   endfunction

   // Read past the stored bytes gives zero.
   function automatic logic [7:0] byte_at(int unsigned pos);
      if (pos < fill && pos < CAPTURE_BYTES) return capture_mem[pos];
      return CHAR_NUL;
   endfunction

   function automatic result_type decode_capture();
      result_type  r;
      int unsigned name_end;
      int unsigned p;
      int          i;
      int          k;
      bit          found;
      bit          stop;
      bit          same;
      logic [7:0]  ch;
      logic [7:0]  s0;
      logic [7:0]  s1;
      logic [7:0]  s2;
      r.command_index = NO_MATCH;
      r.request_kind = KIND_EXECUTE;
      r.error = 1'b1;
      found = 1'b0;
      stop = 1'b0;
      name_end = 0;
      for (p = 0; p < fill && !stop; p++) begin
         ch = byte_at(p);
         if (ch == CHAR_NUL) begin
            stop = 1'b1;
         end else if (ch == CHAR_CR || ch == CHAR_EQ || ch == CHAR_QM || is_num_char(ch)) begin
            name_end = p;
            found = 1'b1;
            stop = 1'b1;
         end
      end
      if (found) begin
         stop = 1'b0;
         for (i = 0; i < TABLE_ENTRIES && i < NAME_SLOTS && !stop; i++) begin
            same = (name_end == entry_name[i].len());
            for (k = 0; same && k < name_end; k++)
               if (byte_at(k) != entry_name[i][k]) same = 1'b0;
            if (same) begin
               r.command_index = i[1:0];
               stop = 1'b1;
            end
         end
      end
      if (r.command_index != NO_MATCH) begin
         s0 = byte_at(name_end);
         s1 = byte_at(name_end + 1);
         s2 = byte_at(name_end + 2);
         if (s0 == CHAR_CR) r.request_kind = KIND_EXECUTE;
         else if (s0 == CHAR_QM && s1 == CHAR_CR) r.request_kind = KIND_QUERY;
         else if (s0 == CHAR_EQ && s1 == CHAR_QM && s2 == CHAR_CR) r.request_kind = KIND_TEST;
         else if (is_num_char(s0) || s0 == CHAR_EQ) r.request_kind = KIND_SETUP;
         else r.request_kind = KIND_MALFORMED;

         if (r.request_kind == KIND_EXECUTE && r.command_index == IDX_EMPTY) begin
            prod_mode = 1'b1;
            r.error = 1'b0;
         end else if (r.request_kind == KIND_EXECUTE && r.command_index == IDX_QUIT) begin
            prod_mode = 1'b0;
            r.error = 1'b0;
         end else if (r.request_kind == KIND_QUERY && r.command_index == IDX_INF) begin
            r.error = 1'b0;
         end
      end
      r.production_mode = prod_mode;
      return r;
   endfunction

   // Note one accepted byte; return 1 when it landed in a capture.
   function automatic bit predict_byte(logic [7:0] c);
      logic [7:0] want;
      if (!in_capture) begin
         want = head_half ? CHAR_T : CHAR_A;
         if (c == want) begin
            if (head_half) begin
               head_half = 1'b0;
               in_capture = 1'b1;
               fill = 0;
            end else begin
               head_half = 1'b1;
            end
         end else begin
            head_half = (c == CHAR_A);
         end
         return 1'b0;
      end
      if (fill < CAPTURE_BYTES) capture_mem[fill] = c;
      fill++;
      if (c == CHAR_CR) begin
         in_capture = 1'b0;
         pending_results.push_back(decode_capture());
      end else if (fill >= CAPTURE_BYTES) begin
         in_capture = 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void check_result(logic [1:0] idx, logic [2:0] kind, logic err,
                                        logic prod);
      result_type want;
      if (pending_results.size() == 0) begin
         $error("result beat with no command pending: index %0d kind %0d", idx, kind);
         mismatch_count++;
         return;
      end
      want = pending_results.pop_front();
      if (idx !== want.command_index) begin
         $error("command_index: expected %0d, got %0d", want.command_index, idx);
         mismatch_count++;
      end
      if (kind !== want.request_kind) begin
         $error("request_kind: expected %0d, got %0d", want.request_kind, kind);
         mismatch_count++;
      end
      if (err !== want.error) begin
         $error("error: expected %0d, got %0d", want.error, err);
         mismatch_count++;
      end
      if (prod !== want.production_mode) begin
         $error("production_mode: expected %0d, got %0d", want.production_mode, prod);
         mismatch_count++;
      end
   endfunction

   function automatic int pending();
      return pending_results.size();
   endfunction
endclass

module at_command_parser_unit_tb;
   localparam int RANDOM_BYTES = 1000;
   localparam int HOLD_LEN = 600;
   localparam int FILL_BYTES = BUFFER_BYTES_DEF;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_command_index;
   logic [2:0] rsp_request_kind;
   logic       rsp_error;
   logic       rsp_production_mode;

   command_result_board board;
   logic [7:0] line_q[$];
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         sent_count = 0;
   logic       hold_go = 1'b0;
   int         hold_cycles = 0;

   at_command_parser_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_command_index(rsp_command_index),
      .rsp_request_kind(rsp_request_kind),
      .rsp_error(rsp_error),
      .rsp_production_mode(rsp_production_mode)
   );

   always #6 clock = ~clock;

   // Result side: check each beat, stall at random, and hold off once for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_command_index, rsp_request_kind, rsp_error,
                               rsp_production_mode);
         if (hold_go && hold_cycles < HOLD_LEN) begin
            hold_cycles <= hold_cycles + 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(board.predict_byte(value));
      sent_count++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_byte(CHAR_CR);
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   task automatic queue_random(input int count, input bit printable);
      int i;
      for (i = 0; i < count; i++)
         line_q.push_back(printable ? 8'($urandom_range(33, 126)) : 8'($urandom_range(255)));
   endtask

   // Build one command line with random content, a mix of well formed and malformed lines.
   task automatic build_command();
      int         n;
      int         i;
      logic [7:0] b;
      line_q.delete();
      if ($urandom_range(99) < 25) queue_random($urandom_range(1, 3), 1'b0);
      if ($urandom_range(99) < 8) queue_text("A");
      queue_text("AT");
      case ($urandom_range(9))
         0, 1: ;
         2, 3: queue_text("+QUIT");
         4, 5: queue_text("+INF");
         6: begin
            case ($urandom_range(4))
               0: queue_text("+QUI");
               1: queue_text("+INFO");
               2: queue_text("+quit");
               3: queue_text("+IN");
               default: queue_text("QUIT");
            endcase
         end
         7: queue_random($urandom_range(1, 6), 1'b1);
         8: queue_random($urandom_range(1, 4), 1'b0);
         default: begin
            queue_text("+");
            line_q.push_back(CHAR_NUL);
            queue_text("INF");
         end
      endcase
      case ($urandom_range(9))
         0, 1, 2: ;
         3, 4: queue_text("?");
         5: queue_text("=?");
         6: begin
            queue_text("=");
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) line_q.push_back(8'($urandom_range(CHAR_0, CHAR_9)));
         end
         7: begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) line_q.push_back(8'($urandom_range(CHAR_0, CHAR_9)));
         end
         8: begin
            queue_text($urandom_range(1) ? "?" : "=");
            queue_random(1, 1'b1);
         end
         default: queue_random($urandom_range(1, 3), 1'b0);
      endcase
      n = $urandom_range(99);
      if (n < 92) begin
         line_q.push_back(CHAR_CR);
      end else if (n < 96) begin
         // drop the terminator: the next line runs into this capture
      end else begin
         n = $urandom_range(FILL_BYTES - 14, FILL_BYTES + 6);
         for (i = 0; i < n; i++) begin
            b = 8'($urandom_range(255));
            line_q.push_back(b == CHAR_CR ? CHAR_A : b);
         end
         if ($urandom_range(1)) line_q.push_back(CHAR_CR);
      end
   endtask

   initial begin
      #10_000_000;
      $display("at_command_parser_unit_tb: errors");
      $finish;
   end

   initial begin
      int i;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 23;
      recv_idle_pct = 58;

      send_line("AT");
      send_line("AT+QUIT");
      send_line("AT+INF?");
      send_line("AT+INF=?");
      send_line("AT+INF=5");
      send_line("AT+QUIT7");
      send_line("AT+INF?x");
      send_line("AT+INF");
      send_line("AT+QUIT?");
      send_line("AT=?");
      send_line("AT?");
      send_line("AT+FOO");
      send_line("AAT+QUIT");
      send_line("atxAyAT");
      send_text("AT+");
      send_byte(CHAR_NUL);
      send_line("QUIT");
      send_text("AT");
      send_byte(CHAR_NUL);
      send_byte(CHAR_CR);
      send_text("AT");
      send_byte(8'hFF);
      send_byte(CHAR_CR);
      // fill the buffer without a terminator: dropped, lone CR ignored
      send_text("AT");
      for (i = 0; i < FILL_BYTES; i++) send_byte("Z");
      send_byte(CHAR_CR);
      // terminator in the last slot is still parsed
      send_text("AT=");
      for (i = 0; i < FILL_BYTES - 2; i++) send_byte("1");
      send_byte(CHAR_CR);
      send_line("AT");

      sent_count = 0;
      hold_go <= 1'b1;
      while (sent_count < RANDOM_BYTES) begin
         if (sent_count < RANDOM_BYTES / 3) begin
            send_idle_pct = 23;
            recv_idle_pct = 58;
         end else if (sent_count < 2 * RANDOM_BYTES / 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         build_command();
         while (line_q.size() != 0) send_byte(line_q.pop_front());
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (FILL_BYTES + 16) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("at_command_parser_unit_tb: clean");
      else
         $display("at_command_parser_unit_tb: errors");
      $finish;
   end
endmodule

/* sim.f */
+incdir+hdl
hdl/atcp_pkg.sv
hdl/atcp_rx.sv
hdl/atcp_byte_unit.sv
hdl/atcp_parse.sv
hdl/at_command_parser_unit.sv
test/at_command_parser_unit_tb.sv
